/* rtl/core/klpm_pkg.sv */
// shared constants, codes and types of the line pattern matcher
`timescale 1ns / 1ps

package klpm_pkg;

   localparam int PATTERN_MAX = 64;
   localparam int LINE_MAX    = 4096;
   localparam int ROW_MAX     = 65536;

   localparam int PAT_AW = $clog2(PATTERN_MAX);
   localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
   localparam int COL_W  = $clog2(LINE_MAX);
   localparam int ROW_W  = $clog2(ROW_MAX);
   localparam int SUM_W  = ((COL_W > LEN_W) ? COL_W : LEN_W) + 1;

   localparam int CHAR_W     = 8;
   localparam int OUT_ROW_W  = 16;
   localparam int OUT_COL_W  = 12;

   typedef enum logic [1:0] {
      CMD_NEW  = 2'd0,
      CMD_PAT  = 2'd1,
      CMD_TEXT = 2'd2,
      CMD_LINE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_SAT  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_FINAL = 2'd2
   } seq_state_type;

   typedef struct packed {
      logic                 found;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] column;
      status_type           status;
   } rsp_type;

endpackage

/* rtl/core/kmp_line_pattern_matcher.sv */
// top level of the line pattern matcher
// answered straight from idle: new search, line end, first or dropped pattern byte, text with no pattern
// other bytes: scan state, repeated per failure-link step, then the final state on a match
// one request in flight; a new byte is taken only once the sequencer is back in idle
// a finished result may wait in the output stage while the next request is taken
// synchronous reset clears counters, lengths and match state; the memories are not cleared
`timescale 1ns / 1ps

module kmp_line_pattern_matcher import klpm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_in
   input  logic [1:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // match_row, match_column, zero fill
   output logic [2:0]  rsp_tuser    // match_found, status
);

   logic    room;
   logic    res_push;
   rsp_type res_data;
   rsp_type out_data;

   klpm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (cmd_type'(req_tuser)),
      .req_char  (req_tdata),
      .room      (room),
      .req_ready (req_tready),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   klpm_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {4'b0000, out_data.column, out_data.row};
   assign rsp_tuser = {out_data.status, out_data.found};

endmodule

/* rtl/core/klpm_ram.sv */
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module klpm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/klpm_seq.sv */
// sequencer: pattern and failure memories, counters and failure-link walk
`timescale 1ns / 1ps

module klpm_seq import klpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  cmd_type           req_cmd,
   input  logic [CHAR_W-1:0] req_char,
   input  logic              room,
   output logic              req_ready,
   output logic              res_push,
   output rsp_type           res_data
);

   seq_state_type     state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [PAT_AW-1:0] prefix_ff, prefix_in;
   logic [LEN_W-1:0]  match_ff, match_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PAT_AW-1:0] k_ff, k_in;
   logic [CHAR_W-1:0] c_ff, c_in;
   logic              pat_mode_ff, pat_mode_in;
   logic [COL_W-1:0]  here_ff, here_in;
   status_type        stat_ff, stat_in;

   logic              p_we;
   logic [PAT_AW-1:0] p_waddr, p_raddr;
   logic [CHAR_W-1:0] p_q;
   logic              f_we;
   logic [PAT_AW-1:0] f_waddr, f_wdata, f_raddr, f_q;

   logic              accept;
   logic              hit;
   logic [LEN_W-1:0]  k_next;
   logic [LEN_W-1:0]  len_m1;
   logic [PAT_AW-1:0] k_start;
   logic [SUM_W-1:0]  here_p1, len_x;

   klpm_ram #(.DEPTH(PATTERN_MAX), .WIDTH(CHAR_W)) u_pat_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (req_char),
      .rd_addr (p_raddr),
      .rd_data (p_q)
   );

   klpm_ram #(.DEPTH(PATTERN_MAX), .WIDTH(PAT_AW)) u_fail_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_addr (f_raddr),
      .rd_data (f_q)
   );

   assign req_ready = (state_ff == ST_IDLE) && room;
   assign accept    = req_valid && req_ready;
   assign hit       = (p_q == c_ff);
   assign k_next    = {1'b0, k_ff} + LEN_W'(hit);
   assign len_m1    = len_ff - LEN_W'(1);
   assign k_start   = (match_ff >= len_ff) ? '0 : match_ff[PAT_AW-1:0];
   assign here_p1   = SUM_W'(here_ff) + SUM_W'(1);
   assign len_x     = SUM_W'(len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         prefix_ff <= '0;
         match_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         prefix_ff <= prefix_in;
         match_ff <= match_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      c_ff        <= c_in;
      pat_mode_ff <= pat_mode_in;
      here_ff     <= here_in;
      stat_ff     <= stat_in;
   end

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      prefix_in   = prefix_ff;
      match_in    = match_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      c_in        = c_ff;
      pat_mode_in = pat_mode_ff;
      here_in     = here_ff;
      stat_in     = stat_ff;
      p_we        = 1'b0;
      p_waddr     = len_ff[PAT_AW-1:0];
      p_raddr     = k_ff;
      f_we        = 1'b0;
      f_waddr     = '0;
      f_wdata     = '0;
      f_raddr     = k_ff - PAT_AW'(1);
      res_push    = 1'b0;
      res_data    = '{found: 1'b0, row: '0, column: '0, status: STAT_OK};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               c_in = req_char;
               case (req_cmd)
                  CMD_NEW: begin
                     len_in    = '0;
                     prefix_in = '0;
                     match_in  = '0;
                     row_in    = '0;
                     col_in    = '0;
                     res_push  = 1'b1;
                  end
                  CMD_PAT: begin
                     if (len_ff >= LEN_W'(PATTERN_MAX)) begin
                        res_push        = 1'b1;
                        res_data.status = STAT_FULL;
                     end else if (len_ff == '0) begin
                        p_we      = 1'b1;
                        f_we      = 1'b1;
                        prefix_in = '0;
                        len_in    = LEN_W'(1);
                        res_push  = 1'b1;
                     end else begin
                        p_we        = 1'b1;
                        k_in        = prefix_ff;
                        p_raddr     = prefix_ff;
                        f_raddr     = prefix_ff - PAT_AW'(1);
                        pat_mode_in = 1'b1;
                        stat_in     = STAT_OK;
                        state_in    = ST_SCAN;
                     end
                  end
                  CMD_TEXT: begin
                     if (col_ff >= COL_W'(LINE_MAX - 1)) begin
                        here_in = COL_W'(LINE_MAX - 1);
                        stat_in = STAT_SAT;
                     end else begin
                        here_in = col_ff;
                        stat_in = STAT_OK;
                        col_in  = col_ff + COL_W'(1);
                     end
                     if (len_ff == '0) begin
                        res_push        = 1'b1;
                        res_data.status = stat_in;
                     end else begin
                        k_in        = k_start;
                        p_raddr     = k_start;
                        f_raddr     = k_start - PAT_AW'(1);
                        pat_mode_in = 1'b0;
                        state_in    = ST_SCAN;
                     end
                  end
                  CMD_LINE: begin
                     if (row_ff >= ROW_W'(ROW_MAX - 1)) begin
                        res_data.status = STAT_SAT;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                     end
                     col_in   = '0;
                     match_in = '0;
                     res_push = 1'b1;
                  end
                  default: begin
                     res_push = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if ((k_ff != '0) && !hit) begin
               // follow the failure link and read the next candidate at once
               k_in    = f_q;
               p_raddr = f_q;
               f_raddr = f_q - PAT_AW'(1);
            end else if (pat_mode_ff) begin
               f_we      = 1'b1;
               f_waddr   = len_ff[PAT_AW-1:0];
               f_wdata   = k_next[PAT_AW-1:0];
               prefix_in = k_next[PAT_AW-1:0];
               len_in    = len_ff + LEN_W'(1);
               res_push  = 1'b1;
               state_in  = ST_IDLE;
            end else if (k_next == len_ff) begin
               f_raddr  = len_m1[PAT_AW-1:0];
               state_in = ST_FINAL;
            end else begin
               match_in        = k_next;
               res_push        = 1'b1;
               res_data.status = stat_ff;
               state_in        = ST_IDLE;
            end
         end
         ST_FINAL: begin
            match_in        = LEN_W'(f_q);
            res_push        = 1'b1;
            res_data.found  = 1'b1;
            res_data.row    = OUT_ROW_W'(row_ff);
            res_data.column = (here_p1 >= len_x) ? OUT_COL_W'(here_p1 - len_x) : '0;
            res_data.status = stat_ff;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> LEN_W'(k_ff) < len_ff)
      else $error("scan position beyond pattern length");

   a_match_below_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (match_ff < len_ff) || (match_ff == '0))
      else $error("match state not below pattern length");

   a_final_after_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL |-> $past(state_ff) == ST_SCAN)
      else $error("final step without preceding scan");

   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(PATTERN_MAX))
      else $error("pattern length over capacity");

   a_single_push: assert property (@(posedge clock) disable iff (reset)
      res_push && (state_ff != ST_IDLE) |=> state_ff == ST_IDLE)
      else $error("sequencer kept working after completing a request");

endmodule

/* rtl/core/klpm_outbuf.sv */
// output register with one skid entry
`timescale 1ns / 1ps

module klpm_outbuf import klpm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    room,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    drain;

   assign drain = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign room      = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule
